[hdl/cfd_pkg.sv]
// ----------------------------------------------------------------------------
// cfd_pkg : shared types and constants for the compass heading unit
// Datapath widths, fixed-point scales and the arctangent table.
// ----------------------------------------------------------------------------
package cfd_pkg;

	// field scaled by 2^24, grown by CORDIC gain and the pre-rotation
	localparam int XW          = 43;
	// angle in 2^-20 degree, up to about +/-190 degrees
	localparam int ZW          = 30;
	localparam int TABLE_LEN   = 24;
	localparam int INPUT_SCALE = 24;
	localparam int OUT_SHIFT   = 13;
	localparam int QW          = ZW - OUT_SHIFT;
	localparam int HW          = QW + 1;
	localparam int WW          = HW + 1;

	localparam logic signed [ZW-1:0] DEG90_Z   = 30'sd94371840;
	localparam logic signed [ZW-1:0] ROUND_BIAS = 30'sd4096;
	localparam logic signed [WW-1:0] FULL_TURN  = 19'sd46080;
	localparam logic signed [WW-1:0] TWO_TURNS  = 19'sd92160;

	typedef struct packed {
		logic                 zero;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cfd_vec_t;

	// atan(2^-i) in 2^-20 degree, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
		logic signed [ZW-1:0] r;
		unique case (idx)
			0:  r = 30'sd47185920;
			1:  r = 30'sd27855475;
			2:  r = 30'sd14718068;
			3:  r = 30'sd7471121;
			4:  r = 30'sd3750058;
			5:  r = 30'sd1876857;
			6:  r = 30'sd938658;
			7:  r = 30'sd469357;
			8:  r = 30'sd234682;
			9:  r = 30'sd117342;
			10: r = 30'sd58671;
			11: r = 30'sd29335;
			12: r = 30'sd14668;
			13: r = 30'sd7334;
			14: r = 30'sd3667;
			15: r = 30'sd1833;
			16: r = 30'sd917;
			17: r = 30'sd458;
			18: r = 30'sd229;
			19: r = 30'sd115;
			20: r = 30'sd57;
			21: r = 30'sd29;
			22: r = 30'sd14;
			23: r = 30'sd7;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hdl/cfd_pre.sv]
// ----------------------------------------------------------------------------
// cfd_pre : input stage
// Registers the field pair, folds the left half plane into the right one
// and scales the vector up for the CORDIC stages.
// ----------------------------------------------------------------------------
module cfd_pre
	import cfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	output logic              ready_in,
	input  logic signed [15:0] fx,
	input  logic signed [15:0] fy,
	output logic              valid_out,
	input  logic              ready_out,
	output cfd_vec_t          vec_out
);

	logic                 valid_s1;
	cfd_vec_t             vec_s1;
	cfd_vec_t             vec_d;
	logic signed [XW-1:0] fxe;
	logic signed [XW-1:0] fye;
	logic signed [XW-1:0] x_sel;
	logic signed [XW-1:0] y_sel;

	assign fxe = {{(XW-16){fx[15]}}, fx};
	assign fye = {{(XW-16){fy[15]}}, fy};

	always_comb begin
		vec_d.zero = (fx == '0) && (fy == '0);
		vec_d.z    = '0;
		x_sel      = fxe;
		y_sel      = fye;
		if (fx[15]) begin
			// turn by 90 degrees into the right half plane
			if (!fy[15]) begin
				x_sel   = fye;
				y_sel   = -fxe;
				vec_d.z = DEG90_Z;
			end else begin
				x_sel   = -fye;
				y_sel   = fxe;
				vec_d.z = -DEG90_Z;
			end
		end
		vec_d.x = x_sel <<< INPUT_SCALE;
		vec_d.y = y_sel <<< INPUT_SCALE;
	end

	assign ready_in = !valid_s1 || ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_in) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in && ready_in) begin
			vec_s1 <= vec_d;
		end
	end

	assign valid_out = valid_s1;
	assign vec_out   = vec_s1;

endmodule

[hdl/cfd_stage.sv]
// ----------------------------------------------------------------------------
// cfd_stage : one vectoring CORDIC iteration
// Rotates the vector towards the X axis by atan(2^-STAGE_IDX), one register.
// ----------------------------------------------------------------------------
module cfd_stage
	import cfd_pkg::*;
#(
	parameter int unsigned STAGE_IDX = 0
)
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid_in,
	output logic     ready_in,
	input  cfd_vec_t vec_in,
	output logic     valid_out,
	input  logic     ready_out,
	output cfd_vec_t vec_out
);

	logic     valid_s1;
	cfd_vec_t vec_s1;
	cfd_vec_t vec_d;

	generate
		if (STAGE_IDX < TABLE_LEN) begin : g_rot
			logic signed [XW-1:0] dx;
			logic signed [XW-1:0] dy;
			logic                 y_pos;

			assign dx    = vec_in.y >>> STAGE_IDX;
			assign dy    = vec_in.x >>> STAGE_IDX;
			assign y_pos = !vec_in.y[XW-1] && (vec_in.y != '0);

			always_comb begin
				vec_d.zero = vec_in.zero;
				if (y_pos) begin
					vec_d.x = vec_in.x + dx;
					vec_d.y = vec_in.y - dy;
					vec_d.z = vec_in.z + atan_entry(STAGE_IDX);
				end else begin
					vec_d.x = vec_in.x - dx;
					vec_d.y = vec_in.y + dy;
					vec_d.z = vec_in.z - atan_entry(STAGE_IDX);
				end
			end
		end else begin : g_pass
			// beyond the table: carry the vector unchanged
			assign vec_d = vec_in;
		end
	endgenerate

	assign ready_in = !valid_s1 || ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_in) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in && ready_in) begin
			vec_s1 <= vec_d;
		end
	end

	assign valid_out = valid_s1;
	assign vec_out   = vec_s1;

endmodule

[hdl/cfd_wrap.sv]
// ----------------------------------------------------------------------------
// cfd_wrap : output stages
// Rounds the angle to 1/128 degree, adds the declination, then wraps the
// heading into one full turn. Two registers; the second is the output.
// ----------------------------------------------------------------------------
module cfd_wrap
	import cfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	output logic               ready_in,
	input  cfd_vec_t           vec_in,
	input  logic signed [15:0] decl,
	output logic               valid_out,
	input  logic               ready_out,
	output logic        [15:0] heading
);

	logic                 valid_s1;
	logic                 valid_s2;
	logic                 ready_s2;
	logic signed [HW-1:0] h_s1;
	logic        [15:0]   heading_s2;

	logic signed [ZW-1:0] z_bias;
	logic signed [QW-1:0] q;
	logic signed [HW-1:0] h_d;
	logic signed [WW-1:0] hw;
	logic signed [WW-1:0] h_wrapped;

	// zero field counts as angle 0
	assign z_bias = (vec_in.zero ? '0 : vec_in.z) + ROUND_BIAS;
	assign q      = z_bias[ZW-1:OUT_SHIFT];
	assign h_d    = {q[QW-1], q} + {{(HW-16){decl[15]}}, decl};

	assign hw = {h_s1[HW-1], h_s1};

	always_comb begin
		priority if (hw < -FULL_TURN) begin
			h_wrapped = hw + TWO_TURNS;
		end else if (hw[WW-1]) begin
			h_wrapped = hw + FULL_TURN;
		end else if (hw >= FULL_TURN) begin
			h_wrapped = hw - FULL_TURN;
		end else begin
			h_wrapped = hw;
		end
	end

	assign ready_s2 = !valid_s2 || ready_out;
	assign ready_in = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_in) begin
				valid_s1 <= valid_in;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in && ready_in) begin
			h_s1 <= h_d;
		end
		if (valid_s1 && ready_s2) begin
			heading_s2 <= h_wrapped[15:0];
		end
	end

	assign valid_out = valid_s2;
	assign heading   = heading_s2;

endmodule

[hdl/compass_heading_from_field_unit.sv]
// ----------------------------------------------------------------------------
// compass_heading_from_field_unit : magnetometer field to compass heading
// Pipelined CORDIC atan2 of the X/Y field, plus declination, wrapped to
// [0, 360) degrees in 1/128 degree units.
// ----------------------------------------------------------------------------
//  channel   | signals                          | handshake
//  ----------+----------------------------------+-----------------------
//  input     | field_x, field_y                 | in_valid / in_ready
//  output    | heading                          | out_valid / out_ready
//  config    | cfg_wr_data (declination)        | cfg_wr_en, no wait
//
//  One item per cycle sustained while out_ready stays high; registers are the
//  input stage, one stage per CORDIC iteration, round/add and wrap stages.
//  Reset clears all stage valid bits and loads declination with 8.
//  Each stage holds while its successor is full and stalled, so bubbles are
//  squeezed out and in_ready stays high while the pipe has a free slot.
// ----------------------------------------------------------------------------
module compass_heading_from_field_unit
	import cfd_pkg::*;
#(
	parameter int unsigned ITERATIONS = 16
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] field_x,
	input  logic signed [15:0] field_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [15:0] heading,
	input  logic               cfg_wr_en,
	input  logic signed [15:0] cfg_wr_data
);

	logic signed [15:0] decl_q;

	cfd_vec_t vec   [0:ITERATIONS];
	logic     vld   [0:ITERATIONS];
	logic     rdy   [0:ITERATIONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= 16'sd8;
		end else if (cfg_wr_en) begin
			decl_q <= cfg_wr_data;
		end
	end

	cfd_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (in_valid),
		.ready_in  (in_ready),
		.fx        (field_x),
		.fy        (field_y),
		.valid_out (vld[0]),
		.ready_out (rdy[0]),
		.vec_out   (vec[0])
	);

	generate
		for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
			cfd_stage #(
				.STAGE_IDX (i)
			) u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.valid_in  (vld[i]),
				.ready_in  (rdy[i]),
				.vec_in    (vec[i]),
				.valid_out (vld[i+1]),
				.ready_out (rdy[i+1]),
				.vec_out   (vec[i+1])
			);
		end
	endgenerate

	cfd_wrap u_wrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (vld[ITERATIONS]),
		.ready_in  (rdy[ITERATIONS]),
		.vec_in    (vec[ITERATIONS]),
		.decl      (decl_q),
		.valid_out (out_valid),
		.ready_out (out_ready),
		.heading   (heading)
	);

	// result always inside one full turn
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heading < 16'd46080))
		else $error("heading outside [0, 360) degrees");

	// a consumer that takes the output frees every stage back to the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is being taken");

	// input can only back up when a result is waiting at the output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without an output stall");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb : testbench for compass_heading_from_field_unit
// Drives X/Y field items and declination settings, predicts each heading
// with its own CORDIC atan2 and checks every result in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          STAGES       = 16;
	localparam int          ATAN_ENTRIES = 24;
	localparam longint      QUARTER_TURN = 64'sd94371840;  // 90 deg in 2^-20 deg
	localparam longint      TURN_LSB     = 64'sd46080;     // 360 deg in 1/128 deg
	localparam int          SCALE_SHIFT  = 24;
	localparam int          ANGLE_DROP   = 13;
	localparam int          LATENCY      = STAGES + 3;
	localparam int          HOLD_CYCLES  = 150;
	localparam int          HOLD_AFTER   = 400;
	localparam int          ITEMS_PER_PHASE = 158;
	localparam int          N_PHASES     = 7;

	// scoreboard: expected headings in acceptance order
	class heading_ledger;
		logic [15:0]        due_headings[$];
		logic signed [15:0] declination;
		int unsigned        faults;
		longint             atan_step[ATAN_ENTRIES];

		function new();
			atan_step = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
				938658, 469357, 234682, 117342, 58671, 29335,
				14668, 7334, 3667, 1833, 917, 458,
				229, 115, 57, 29, 14, 7};
			declination = 16'sd8;
			faults      = 0;
		endfunction

		function void set_declination(logic signed [15:0] v);
			declination = v;
		endfunction

		function logic [15:0] heading_for(logic signed [15:0] fx, logic signed [15:0] fy);
			longint x, y, z, dx, dy, q, h;
			x = 0;
			y = 0;
			z = 0;
			if (!(fx == 0 && fy == 0)) begin
				// left half plane: turn by 90 degrees first
				if (fx < 0) begin
					if (fy >= 0) begin
						x = fy;
						y = -longint'(fx);
						z = QUARTER_TURN;
					end else begin
						x = -longint'(fy);
						y = fx;
						z = -QUARTER_TURN;
					end
				end else begin
					x = fx;
					y = fy;
				end
				x = x <<< SCALE_SHIFT;
				y = y <<< SCALE_SHIFT;
				for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
					dx = y >>> i;
					dy = x >>> i;
					if (y > 0) begin
						x += dx;
						y -= dy;
						z += atan_step[i];
					end else begin
						x -= dx;
						y += dy;
						z -= atan_step[i];
					end
				end
			end
			q = (z + (64'sd1 <<< (ANGLE_DROP - 1))) >>> ANGLE_DROP;
			h = (q + longint'(declination)) % TURN_LSB;
			if (h < 0)
				h += TURN_LSB;
			return h[15:0];
		endfunction

		function void note_field(logic signed [15:0] fx, logic signed [15:0] fy);
			due_headings.push_back(heading_for(fx, fy));
		endfunction

		function void check_heading(logic [15:0] got);
			logic [15:0] want;
			if (due_headings.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: heading %0d with no item outstanding", $realtime, got);
				return;
			end
			want = due_headings.pop_front();
			if (got !== want) begin
				faults++;
				if (faults <= 10)
					$display("%0t: heading mismatch, expected %0d, got %0d",
						$realtime, want, got);
			end
		endfunction

		function int pending();
			return due_headings.size();
		endfunction
	endclass

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic signed [15:0] field_x     = '0;
	logic signed [15:0] field_y     = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic        [15:0] heading;
	logic               cfg_wr_en   = 1'b0;
	logic signed [15:0] cfg_wr_data = '0;

	heading_ledger ledger = new();
	int unsigned   items_in      = 0;
	int unsigned   send_idle_pct = 18;
	int unsigned   recv_idle_pct = 71;

	compass_heading_from_field_unit #(.ITERATIONS(STAGES)) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.field_x     (field_x),
		.field_y     (field_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.heading     (heading),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_field(input logic signed [15:0] fx, input logic signed [15:0] fy);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		field_x  = fx;
		field_y  = fy;
		do
			@(posedge clk);
		while (!in_ready);
		ledger.note_field(fx, fy);
		items_in++;
	endtask

	task automatic write_declination(input logic signed [15:0] v);
		@(negedge clk);
		in_valid    = 1'b0;
		cfg_wr_en   = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		ledger.set_declination(v);
	endtask

	// stop offering before waiting, so the last item is not taken again
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_field();
		case ($urandom_range(7))
			0:       return 16'sd0;
			1:       return -16'sd32768;
			2:       return 16'sd32767;
			3:       return 16'($signed($urandom_range(16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	// receiver: random stalls plus one long hold-off to back the pipe up
	initial begin
		int unsigned hold_left;
		bit          held;
		hold_left = 0;
		held      = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && items_in >= HOLD_AFTER) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_heading(heading);
	end

	initial begin
		logic signed [15:0] plan[N_PHASES];
		logic signed [15:0] corner[20][2];
		plan   = '{16'sd8, -16'sd23040, 16'sd23040, 16'sd0, -16'sd32768, 16'sd32767,
			16'sd0};
		plan[6] = 16'($urandom_range(46080) - 23040);
		corner = '{'{16'sd0, 16'sd0}, '{16'sd32767, 16'sd0}, '{-16'sd32768, 16'sd0},
			'{16'sd0, 16'sd32767}, '{16'sd0, -16'sd32768}, '{-16'sd32768, -16'sd32768},
			'{16'sd32767, 16'sd32767}, '{-16'sd32768, 16'sd32767},
			'{16'sd32767, -16'sd32768}, '{-16'sd1, 16'sd0}, '{-16'sd1, -16'sd1},
			'{16'sd1, 16'sd1}, '{16'sd1, -16'sd1}, '{-16'sd1, 16'sd1},
			'{16'sd0, 16'sd1}, '{16'sd0, -16'sd1}, '{16'sd1, 16'sd0},
			'{-16'sd32768, -16'sd1}, '{-16'sd32768, 16'sd1}, '{-16'sd5, 16'sd3}};

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed items at the reset declination
		foreach (corner[i])
			send_field(corner[i][0], corner[i][1]);

		for (int p = 0; p < N_PHASES; p++) begin
			if (p > 0) begin
				drain();
				write_declination(plan[p]);
			end
			if (p >= 5) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (p >= 3) begin
				send_idle_pct = 71;
				recv_idle_pct = 18;
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_field(pick_field(), pick_field());
		end

		@(negedge clk);
		in_valid = 1'b0;
		drain();
		repeat (LATENCY + 4) @(posedge clk);
		ledger.faults += ledger.pending();
		if (ledger.faults == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
